>>> sv/btc_pkg.sv
// ---------------------------------------------------------------------------
// btc_pkg: shared types and constants of the block tape controller
// Holds the operation and register codes, the command and status masks,
// the input item type that the queue carries and the result item type.
// ---------------------------------------------------------------------------
`default_nettype none
package btc_pkg;

    localparam int START_DELAY = 6;
    localparam int UNIT_COUNT  = 8;
    localparam int LAST_BLOCK  = 577;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_READ  = 3'd0,
        OP_WRITE = 3'd1,
        OP_INIT  = 3'd2,
        OP_TICK  = 3'd3,
        OP_REPLY = 3'd4
    } op_t;

    localparam logic [2:0] REG_STATUS  = 3'd0;
    localparam logic [2:0] REG_COMMAND = 3'd1;
    localparam logic [2:0] REG_WCOUNT  = 3'd2;
    localparam logic [2:0] REG_BADDR   = 3'd3;
    localparam logic [2:0] REG_DATA    = 3'd4;

    localparam logic [2:0] CMD_STOP_ALL = 3'd0;
    localparam logic [2:0] CMD_SEARCH   = 3'd1;
    localparam logic [2:0] CMD_READ     = 3'd2;
    localparam logic [2:0] CMD_STOP_SEL = 3'd4;
    localparam logic [2:0] CMD_MARKS    = 3'd5;
    localparam logic [2:0] CMD_WRITE    = 3'd6;

    localparam logic [15:0] CMD_READ_MASK   = 16'o137776;
    localparam logic [15:0] CMD_WRITE_MASK  = 16'o177577;
    localparam logic [15:0] ST_UNIT_ERR     = 16'o004000;
    localparam logic [15:0] BIT_ERROR       = 16'o100000;
    localparam logic [15:0] ST_WRITE_MASK   = 16'o014377;
    localparam logic [15:0] ST_INIT_MASK    = 16'o014134;
    localparam logic [15:0] CMD_INIT_MASK   = 16'o140201;
    localparam logic [15:0] BIT_READY       = 16'o000200;
    localparam logic [15:0] CMD_FINISH_MASK = 16'o077776;
    localparam logic [15:0] ST_MEDIUM_ERR   = 16'o002000;
    localparam logic [15:0] BIT_IE          = 16'o000100;
    localparam logic [15:0] ST_PLAIN_MASK   = 16'o000177;
    localparam logic [15:0] ADDR_MASK       = 16'o177776;

    // decoded input transaction
    typedef struct packed {
        logic        is_read;
        logic        is_write;
        logic        is_init;
        logic        is_tick;
        logic        is_reply;
        logic [2:0]  reg_select;
        logic [15:0] write_data;
        logic [15:0] tape_word;
        logic [15:0] memory_word;
        logic        medium_ok;
    } item_t;

    typedef struct packed {
        logic [15:0] store_word;
        logic        store_valid;
        logic [17:0] memory_address;
        logic [15:0] word_offset;
        logic [9:0]  tape_block;
        logic [2:0]  transfer_unit;
        logic        transfer_to_tape;
        logic        transfer_request;
        logic        interrupt_request;
        logic        bus_error;
        logic [15:0] read_data;
    } result_t;

endpackage
`default_nettype wire

>>> sv/btc_front.sv
// ---------------------------------------------------------------------------
// btc_front: input acceptance, decode and item queue
// Decodes the operation of each input transaction and holds decoded items
// in a short queue for the execution side.
// ---------------------------------------------------------------------------
`default_nettype none
module btc_front import btc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  operation,
    input  wire logic [2:0]  reg_select,
    input  wire logic [15:0] write_data,
    input  wire logic [15:0] tape_word,
    input  wire logic [15:0] memory_word,
    input  wire logic        medium_ok,
    output logic             q_valid,
    input  wire logic        q_ready,
    output item_t            q_item
);

    item_t      mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      dec;
    logic       push, pop;

    always_comb begin
        dec             = '0;
        dec.is_read     = (operation == OP_READ);
        dec.is_write    = (operation == OP_WRITE);
        dec.is_init     = (operation == OP_INIT);
        dec.is_tick     = (operation == OP_TICK);
        dec.is_reply    = (operation == OP_REPLY);
        dec.reg_select  = reg_select;
        dec.write_data  = write_data;
        dec.tape_word   = tape_word;
        dec.memory_word = memory_word;
        dec.medium_ok   = medium_ok;
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

>>> sv/btc_back.sv
// ---------------------------------------------------------------------------
// btc_back: register file, command sequencing and result buffer
// Executes one decoded item per cycle, unless the output buffer is full
// and out_ready is low, and places its result in a two-entry output buffer.
// ---------------------------------------------------------------------------
`default_nettype none
module btc_back import btc_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire item_t q_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   out_result
);

    logic [15:0]       status_reg, status_next;
    logic [15:0]       command_reg, command_next;
    logic [15:0]       wcount_reg, wcount_next;
    logic [15:0]       baddr_reg, baddr_next;
    logic [15:0]       data_reg, data_next;
    logic [2:0]        unit_reg, unit_next;
    logic [2:0]        countdown_reg, countdown_next;
    logic signed [10:0] pos_reg [8];
    logic signed [10:0] pos_next [8];
    logic              active_reg, active_next;
    logic [15:0]       moved_reg, moved_next;
    logic              dir_reg, dir_next;

    result_t           res;
    result_t           buf_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              exec, pop;

    assign out_valid  = (count_reg != 2'd0);
    assign out_result = buf_reg[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign q_ready    = (count_reg != 2'd2) || out_ready;
    assign exec       = q_valid && q_ready;

    always_comb begin
        logic signed [11:0] p;
        logic signed [10:0] pcur;
        logic [17:0]        addr;
        logic               unit_ok;
        logic               fin;
        logic               xfin;

        status_next    = status_reg;
        command_next   = command_reg;
        wcount_next    = wcount_reg;
        baddr_next     = baddr_reg;
        data_next      = data_reg;
        unit_next      = unit_reg;
        countdown_next = countdown_reg;
        pos_next       = pos_reg;
        active_next    = active_reg;
        moved_next     = moved_reg;
        dir_next       = dir_reg;
        res            = '0;
        p              = '0;
        addr           = '0;
        fin            = 1'b0;
        xfin           = 1'b0;
        unit_ok        = ({1'b0, unit_reg} < 4'(UNIT_COUNT));
        pcur           = unit_ok ? pos_reg[unit_reg] : 11'sd0;

        priority if (q_item.is_read) begin
            unique case (q_item.reg_select)
                REG_STATUS:  res.read_data = status_reg;
                REG_COMMAND: res.read_data = command_reg & CMD_READ_MASK;
                REG_WCOUNT:  res.read_data = wcount_reg;
                REG_BADDR:   res.read_data = baddr_reg & ADDR_MASK;
                REG_DATA:    res.read_data = data_reg;
                default:     res.bus_error = 1'b1;
            endcase
        end else if (q_item.is_write) begin
            unique case (q_item.reg_select)
                REG_COMMAND: begin
                    command_next = (command_reg & BIT_READY)
                                 | (q_item.write_data & CMD_WRITE_MASK);
                    unit_next = command_next[10:8];
                    if (unit_next == 3'd0) begin
                        status_next = status_next & ~ST_UNIT_ERR;
                    end else begin
                        status_next    = status_next | ST_UNIT_ERR;
                        command_next   = command_next | BIT_ERROR;
                        countdown_next = '0;
                    end
                    if (command_next[0]) begin
                        command_next   = command_next & 16'o177576;
                        countdown_next = 3'(START_DELAY);
                    end
                    if (!command_next[15]) status_next = status_next & ST_WRITE_MASK;
                end
                REG_WCOUNT: wcount_next = q_item.write_data;
                REG_BADDR:  baddr_next  = q_item.write_data & ADDR_MASK;
                default:    res.bus_error = 1'b1;
            endcase
        end else if (q_item.is_init) begin
            status_next  = status_reg & ST_INIT_MASK;
            command_next = (command_reg & CMD_INIT_MASK) | BIT_READY;
            wcount_next  = '0;
            baddr_next   = '0;
            data_next    = '0;
            unit_next    = '0;
            for (int i = 0; i < 8; i++) pos_next[i] = '0;
            active_next  = 1'b0;
            moved_next   = '0;
        end else if (q_item.is_tick) begin
            if (!active_reg && countdown_reg != 3'd0) begin
                countdown_next = countdown_reg - 3'd1;
                if (countdown_next == 3'd0) begin
                    unique case (command_reg[3:1])
                        CMD_STOP_ALL, CMD_STOP_SEL: fin = 1'b1;
                        CMD_MARKS: begin
                            if (unit_ok) pos_next[unit_reg] = '0;
                            fin = 1'b1;
                        end
                        CMD_SEARCH: begin
                            p = command_reg[11] ? 12'(pcur) - 12'sd1 : 12'(pcur) + 12'sd1;
                            if (p < 0 || p > 12'sd577 - 12'sd577 + 12'(LAST_BLOCK)) begin
                                if (p > 12'(LAST_BLOCK)) p = 12'(LAST_BLOCK);
                                status_next  = (status_reg & ~BIT_READY) | BIT_ERROR;
                                command_next = command_reg | BIT_ERROR;
                            end else begin
                                status_next = (status_reg & 16'o077777) | BIT_READY;
                            end
                            if (p < -12'sd1024) p = -12'sd1024;
                            if (unit_ok) begin
                                pos_next[unit_reg] = p[10:0];
                                data_next = {{5{p[10]}}, p[10:0]};
                            end else begin
                                data_next = '0;
                            end
                            command_next = (command_next & 16'o177776) | BIT_READY;
                            res.interrupt_request = command_next[6];
                        end
                        CMD_READ, CMD_WRITE: begin
                            if (pcur < 0 || 12'(pcur) > 12'(LAST_BLOCK)) begin
                                status_next  = (status_reg & ~BIT_READY) | BIT_ERROR;
                                command_next = command_reg | BIT_ERROR | BIT_READY;
                                res.interrupt_request = command_next[6];
                            end else if (wcount_reg == 16'd0) begin
                                xfin = 1'b1;
                            end else begin
                                dir_next                 = (command_reg[3:1] == CMD_WRITE);
                                active_next              = 1'b1;
                                moved_next               = '0;
                                res.transfer_request     = 1'b1;
                                res.transfer_to_tape     = dir_next;
                                res.transfer_unit        = unit_reg;
                                res.tape_block           = pcur[9:0];
                                res.word_offset          = '0;
                                res.memory_address       = {command_reg[5:4], baddr_reg};
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end else if (q_item.is_reply) begin
            if (active_reg) begin
                res.transfer_to_tape = dir_reg;
                res.transfer_unit    = unit_reg;
                res.tape_block       = pcur[9:0];
                res.word_offset      = moved_reg;
                res.memory_address   = {command_reg[5:4], baddr_reg};
                if (dir_reg) begin
                    res.store_valid = 1'b1;
                    res.store_word  = q_item.memory_word;
                end else begin
                    res.store_valid = q_item.medium_ok;
                    res.store_word  = q_item.medium_ok ? q_item.tape_word : 16'd0;
                end
                if (!q_item.medium_ok) begin
                    status_next  = status_next | ST_MEDIUM_ERR;
                    command_next = command_next | BIT_ERROR;
                end
                wcount_next = wcount_reg + 16'd1;
                moved_next  = moved_reg + 16'd1;
                addr        = {command_reg[5:4], baddr_reg} + 18'd2;
                baddr_next  = addr[15:0];
                command_next[5:4] = addr[17:16];
                if (wcount_next != 16'd0 && q_item.medium_ok) res.transfer_request = 1'b1;
                else xfin = 1'b1;
            end
        end else begin
        end

        if (fin) begin
            status_next  = status_next & ST_PLAIN_MASK;
            command_next = (command_next & CMD_FINISH_MASK) | BIT_READY;
            res.interrupt_request = command_next[6];
        end
        if (xfin) begin
            status_next  = (status_next & 16'o077777) | BIT_READY;
            command_next = (command_next & CMD_FINISH_MASK) | BIT_READY;
            active_next  = 1'b0;
            res.interrupt_request = command_next[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            buf_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg    <= '0;
            command_reg   <= BIT_READY;
            wcount_reg    <= '0;
            baddr_reg     <= '0;
            data_reg      <= '0;
            unit_reg      <= '0;
            countdown_reg <= '0;
            for (int i = 0; i < 8; i++) pos_reg[i] <= '0;
            active_reg    <= 1'b0;
            moved_reg     <= '0;
            dir_reg       <= 1'b0;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
        end else begin
            if (exec) begin
                status_reg    <= status_next;
                command_reg   <= command_next;
                wcount_reg    <= wcount_next;
                baddr_reg     <= baddr_next;
                data_reg      <= data_next;
                unit_reg      <= unit_next;
                countdown_reg <= countdown_next;
                pos_reg       <= pos_next;
                active_reg    <= active_next;
                moved_reg     <= moved_next;
                dir_reg       <= dir_next;
                wr_ptr_reg    <= ~wr_ptr_reg;
            end
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, exec} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

>>> sv/block_tape_controller.sv
// ---------------------------------------------------------------------------
// block_tape_controller: block-addressed tape controller
// Register access, bus init, ticks and word replies drive a five-register
// tape controller that keeps a block position for each unit.
// ---------------------------------------------------------------------------
//  channel  | direction | contents
//  s_       | in        | one operation: read, write, init, tick or reply
//  m_       | out       | one result transaction for each input transaction
//
//  one transaction per cycle sustained while m_tready stays high; each input
//  passes the decode queue, then the execute stage and its result buffer
//  synchronous active-low reset restores the register reset values
//  a stalled m_ side fills the two-entry result buffer, then the two-entry
//  input queue, before s_tready falls
// ---------------------------------------------------------------------------
`default_nettype none
module block_tape_controller import btc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] operation, [5:3] reg_select
    input  wire logic [5:0]  s_tuser,
    // [15:0] write_data, [31:16] tape_word, [47:32] memory_word, [48] medium_ok
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] read_data, [16] bus_error, [17] interrupt_request,
    // [18] transfer_request, [19] transfer_to_tape, [22:20] transfer_unit,
    // [32:23] tape_block, [48:33] word_offset, [66:49] memory_address,
    // [67] store_valid, [83:68] store_word
    output logic [87:0]      m_tdata
);

    logic    q_valid, q_ready;
    item_t   q_item;
    result_t res;

    // front: accept and decode into the item queue
    btc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .operation   (s_tuser[2:0]),
        .reg_select  (s_tuser[5:3]),
        .write_data  (s_tdata[15:0]),
        .tape_word   (s_tdata[31:16]),
        .memory_word (s_tdata[47:32]),
        .medium_ok   (s_tdata[48]),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    // back: controller state and result buffer
    btc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    // result fields packed from the lowest bit up, padded to whole bytes
    assign m_tdata = {4'd0, res};

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the block tape controller
// Drives register accesses, bus inits, ticks and word replies into the s_
// channel with random gaps, predicts each result transaction in a local
// model of the controller and compares it field by field on the m_ channel.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import btc_pkg::*;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  rsel;
        logic [15:0] wdata;
        logic [15:0] tword;
        logic [15:0] mword;
        logic        ok;
    } stim_t;

    typedef struct {
        stim_t       s;
        logic        chk;     // typed-in expectation present
        logic [87:0] res;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [5:0]  s_tuser;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;

    block_tape_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // controller state of the predictor
    logic [15:0] st_q, cmd_q, wc_q, ba_q, dat_q, moved_q;
    logic [2:0]  unit_q, cdown_q;
    int          pos_q [8];
    logic        xfer_q, to_tape_q;

    logic [87:0] expected_results [$];
    int          mismatches;
    int          idle_cycles;
    int          sent;            // accepted input transactions
    bit          quiet;           // no idling when set

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [87:0] pack_result(logic [15:0] rd, logic be, logic irq,
            logic req, logic tt, logic [2:0] u, logic [9:0] blk, logic [15:0] wo,
            logic [17:0] ma, logic sv, logic [15:0] sw);
        return {4'd0, sw, sv, ma, wo, blk, u, tt, req, irq, be, rd};
    endfunction

    function automatic int unit_pos();
        return (unit_q < UNIT_COUNT) ? pos_q[unit_q] : 0;
    endfunction

    function automatic void set_unit_pos(int p);
        if (p < -1024) p = -1024;
        if (p > 1023) p = 1023;
        if (unit_q < UNIT_COUNT) pos_q[unit_q] = p;
    endfunction

    function automatic logic [17:0] cur_addr();
        return {cmd_q[5:4], ba_q};
    endfunction

    task automatic reset_model();
        st_q = '0; cmd_q = BIT_READY; wc_q = '0; ba_q = '0; dat_q = '0;
        unit_q = '0; cdown_q = '0; xfer_q = 1'b0; moved_q = '0; to_tape_q = 1'b0;
        foreach (pos_q[i]) pos_q[i] = 0;
    endtask

    // finish of a transfer or a zero-count transfer
    task automatic end_transfer(inout logic irq);
        st_q  = (st_q & 16'o077777) | BIT_READY;
        cmd_q = (cmd_q & CMD_FINISH_MASK) | BIT_READY;
        xfer_q = 1'b0;
        if (cmd_q & BIT_IE) irq = 1'b1;
    endtask

    // predicts the result of one accepted transaction and updates the state
    task automatic predict_controller(input stim_t s, output logic [87:0] r);
        logic [15:0] rd, sw;
        logic        be, irq, req, sv, fill;
        logic [2:0]  fcode;
        logic [17:0] a;
        int          p;
        rd = '0; sw = '0; be = 0; irq = 0; req = 0; sv = 0; fill = 0;
        case (s.op)
            OP_READ: begin
                case (s.rsel)
                    REG_STATUS:  rd = st_q;
                    REG_COMMAND: rd = cmd_q & CMD_READ_MASK;
                    REG_WCOUNT:  rd = wc_q;
                    REG_BADDR:   rd = ba_q & ADDR_MASK;
                    REG_DATA:    rd = dat_q;
                    default:     be = 1'b1;
                endcase
            end
            OP_WRITE: begin
                if (s.rsel == REG_COMMAND) begin
                    cmd_q  = (cmd_q & BIT_READY) | (s.wdata & CMD_WRITE_MASK);
                    unit_q = cmd_q[10:8];
                    if (unit_q == 0) st_q &= ~ST_UNIT_ERR;
                    else begin
                        st_q |= ST_UNIT_ERR;
                        cmd_q |= BIT_ERROR;
                        cdown_q = '0;
                    end
                    if (cmd_q[0]) begin
                        cmd_q &= 16'o177576;
                        cdown_q = 3'(START_DELAY);
                    end
                    if (!cmd_q[15]) st_q &= ST_WRITE_MASK;
                end else if (s.rsel == REG_WCOUNT) wc_q = s.wdata;
                else if (s.rsel == REG_BADDR) ba_q = s.wdata & ADDR_MASK;
                else be = 1'b1;
            end
            OP_INIT: begin
                st_q  &= ST_INIT_MASK;
                cmd_q  = (cmd_q & CMD_INIT_MASK) | BIT_READY;
                wc_q = '0; ba_q = '0; dat_q = '0; unit_q = '0;
                foreach (pos_q[i]) pos_q[i] = 0;
                xfer_q = 1'b0; moved_q = '0;
            end
            OP_TICK: begin
                if (!xfer_q && cdown_q != 0) begin
                    cdown_q--;
                    if (cdown_q == 0) begin
                        fcode = cmd_q[3:1];
                        p = unit_pos();
                        case (fcode)
                            CMD_STOP_ALL, CMD_STOP_SEL, CMD_MARKS: begin
                                if (fcode == CMD_MARKS) set_unit_pos(0);
                                st_q &= ST_PLAIN_MASK;
                                cmd_q = (cmd_q & CMD_FINISH_MASK) | BIT_READY;
                                if (cmd_q & BIT_IE) irq = 1'b1;
                            end
                            CMD_SEARCH: begin
                                if (cmd_q[11]) p--; else p++;
                                if (p < 0 || p > LAST_BLOCK) begin
                                    if (p > LAST_BLOCK) p = LAST_BLOCK;
                                    st_q = (st_q & ~BIT_READY) | BIT_ERROR;
                                    cmd_q |= BIT_ERROR;
                                end else st_q = (st_q & 16'o077777) | BIT_READY;
                                set_unit_pos(p);
                                dat_q = 16'(unit_pos());
                                cmd_q = (cmd_q & 16'o177776) | BIT_READY;
                                if (cmd_q & BIT_IE) irq = 1'b1;
                            end
                            CMD_READ, CMD_WRITE: begin
                                if (p < 0 || p > LAST_BLOCK) begin
                                    st_q = (st_q & ~BIT_READY) | BIT_ERROR;
                                    cmd_q |= 16'o100200;
                                    if (cmd_q & BIT_IE) irq = 1'b1;
                                end else if (wc_q == 0) end_transfer(irq);
                                else begin
                                    to_tape_q = (fcode == CMD_WRITE);
                                    xfer_q = 1'b1; moved_q = '0;
                                    req = 1'b1; fill = 1'b1;
                                end
                            end
                            default: ;   // read-all, write-all: nothing
                        endcase
                    end
                end
            end
            OP_REPLY: begin
                if (xfer_q) begin
                    fill = 1'b1;
                    r = pack_result(0, 0, 0, 0, to_tape_q, unit_q, 10'(unit_pos()),
                                    moved_q, cur_addr(), 0, 0);
                    if (to_tape_q) begin sv = 1; sw = s.mword; end
                    else begin sv = s.ok; sw = s.ok ? s.tword : 16'd0; end
                    if (!s.ok) begin st_q |= ST_MEDIUM_ERR; cmd_q |= BIT_ERROR; end
                    wc_q++; moved_q++;
                    a = cur_addr() + 18'd2;
                    ba_q = a[15:0];
                    cmd_q[5:4] = a[17:16];
                    if (wc_q != 0 && s.ok) req = 1'b1;
                    else end_transfer(irq);
                    r[87:17] = {4'd0, sw, sv, r[66:19], req, irq};
                    return;
                end
            end
            default: ;
        endcase
        if (fill)
            r = pack_result(rd, be, irq, req, to_tape_q, unit_q, 10'(unit_pos()),
                            moved_q, cur_addr(), sv, sw);
        else
            r = pack_result(rd, be, irq, req, 0, 0, 0, 0, 0, sv, sw);
    endtask

    // one input transaction: drive at falling edge, wait for acceptance
    task automatic send_item(input stim_t s, input logic chk, input logic [87:0] res);
        logic [87:0] r;
        while (!quiet && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {s.rsel, s.op};
        s_tdata  <= {7'd0, s.ok, s.mword, s.tword, s.wdata};
        do @(posedge aclk); while (!s_tready);
        predict_controller(s, r);
        sent++;
        if (chk && r !== res)
            $display("typed-in expectation differs from predictor: %h vs %h", res, r);
        expected_results.push_back(chk ? res : r);
        @(negedge aclk);
    endtask

    function automatic stim_t mk(logic [2:0] op, logic [2:0] rs, logic [15:0] wd);
        stim_t s;
        s.op = op; s.rsel = rs; s.wdata = wd;
        s.tword = 16'($urandom); s.mword = 16'($urandom); s.ok = 1'b1;
        return s;
    endfunction

    function automatic stim_t rand_noise();
        stim_t s;
        s = mk(3'($urandom_range(7)), 3'($urandom_range(7)), 16'($urandom));
        s.ok = 1'($urandom_range(1));
        return s;
    endfunction

    // result side: random stalls, compare against oldest expectation
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
    end

    always @(posedge aclk) begin
        logic [87:0] e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %h", m_tdata);
            end else begin
                e = expected_results.pop_front();
                if (m_tdata !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp rd=%h be=%b irq=%b req=%b tt=%b u=%0d blk=%0d wo=%0d ma=%h sv=%b sw=%h | act rd=%h be=%b irq=%b req=%b tt=%b u=%0d blk=%0d wo=%0d ma=%h sv=%b sw=%h",
                            e[15:0], e[16], e[17], e[18], e[19], e[22:20], e[32:23], e[48:33],
                            e[66:49], e[67], e[83:68], m_tdata[15:0], m_tdata[16], m_tdata[17],
                            m_tdata[18], m_tdata[19], m_tdata[22:20], m_tdata[32:23],
                            m_tdata[48:33], m_tdata[66:49], m_tdata[67], m_tdata[83:68]);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // a command write, the delay ticks, and replies while a transfer runs
    task automatic run_command_seq(input logic [15:0] cmd, input int fail_pct);
        stim_t s;
        int n;
        send_item(mk(OP_WRITE, REG_COMMAND, cmd), 0, '0);
        for (int i = 0; i < START_DELAY; i++) send_item(mk(OP_TICK, 0, 0), 0, '0);
        n = 0;
        while (xfer_q && n < 40) begin
            s = mk(OP_REPLY, 0, 0);
            s.ok = ($urandom_range(99) >= fail_pct);
            if ($urandom_range(9) == 0) s = ($urandom_range(1)) ? mk(OP_TICK, 0, 0) : rand_noise();
            send_item(s, 0, '0);
            n++;
        end
    endtask

    function automatic logic [15:0] rand_cmd(logic [2:0] fn);
        logic [15:0] c;
        c = 16'($urandom);
        c[3:1] = fn; c[0] = 1'b1;
        if ($urandom_range(9) != 0) c[10:8] = 3'd0;
        return c;
    endfunction

    row_t rows [$];

    initial begin
        row_t r;
        logic [2:0] fn;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tuser = '0; s_tdata = '0; m_tready = 1'b0;
        mismatches = 0; idle_cycles = 0; quiet = 1'b0; sent = 0;
        reset_model();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table: reset values, bad registers, extremes
        r.chk = 1;
        r.s = mk(OP_READ, REG_COMMAND, 0); r.res = pack_result(BIT_READY, 0,0,0,0,0,0,0,0,0,0);
        rows.push_back(r);
        r.s = mk(OP_READ, REG_STATUS, 0); r.res = '0; rows.push_back(r);
        r.s = mk(OP_READ, 3'd5, 0); r.res = pack_result(0, 1,0,0,0,0,0,0,0,0,0);
        rows.push_back(r);
        r.s = mk(OP_READ, 3'd7, 0); rows.push_back(r);
        r.s = mk(OP_WRITE, REG_STATUS, 16'hFFFF); rows.push_back(r);
        r.s = mk(OP_WRITE, REG_DATA, 16'hFFFF); rows.push_back(r);
        r.s = mk(OP_WRITE, 3'd6, 16'hFFFF); rows.push_back(r);
        r.chk = 0;
        r.s = mk(OP_WRITE, REG_BADDR, 16'hFFFF); rows.push_back(r);
        r.s = mk(OP_READ, REG_BADDR, 0); rows.push_back(r);
        r.s = mk(OP_WRITE, REG_WCOUNT, 16'hFFFF); rows.push_back(r);
        r.s = mk(OP_READ, REG_WCOUNT, 0); rows.push_back(r);
        r.s = mk(OP_WRITE, REG_COMMAND, 16'hFFFF); rows.push_back(r);
        r.s = mk(OP_READ, REG_COMMAND, 0); rows.push_back(r);
        r.s = mk(OP_READ, REG_STATUS, 0); rows.push_back(r);
        r.s = mk(OP_INIT, 0, 0); rows.push_back(r);
        r.s = mk(3'd7, 0, 0); rows.push_back(r);
        r.s = mk(3'd5, 0, 0); rows.push_back(r);
        r.s = mk(OP_REPLY, 0, 0); rows.push_back(r);
        r.s = mk(OP_TICK, 0, 0); rows.push_back(r);
        foreach (rows[i]) send_item(rows[i].s, rows[i].chk, rows[i].res);

        // backward search from block 0 into the end zone, then rewind
        run_command_seq(16'o004103, 0);
        run_command_seq(16'o000113, 0);
        run_command_seq(16'o000105, 0);     // read data at block 0
        send_item(mk(OP_WRITE, REG_WCOUNT, 16'hFFFD), 0, '0);
        run_command_seq(16'o000115, 0);     // write data, three words
        send_item(mk(OP_WRITE, REG_WCOUNT, 16'hFFFE), 0, '0);
        run_command_seq(16'o000105, 50);    // read data with medium failure
        send_item(mk(OP_WRITE, REG_WCOUNT, 0), 0, '0);
        run_command_seq(16'o000105, 0);     // zero count
        run_command_seq(16'o000117, 0);     // read-all
        run_command_seq(16'o000111, 0);     // stop selected
        run_command_seq(16'o000101, 0);     // stop all

        // random part: mostly well-formed command sequences
        while (sent < 1350) begin
            quiet = (sent > 500 && sent < 700);
            case ($urandom_range(9))
                0, 1: begin
                    send_item(rand_noise(), 0, '0);
                end
                2: begin
                    send_item(mk(OP_WRITE, REG_WCOUNT,
                        ($urandom_range(3) == 0) ? 16'($urandom) : 16'(-$urandom_range(12))), 0, '0);
                    send_item(mk(OP_WRITE, REG_BADDR, 16'($urandom)), 0, '0);
                end
                3: begin
                    send_item(mk(OP_READ, 3'($urandom_range(7)), 0), 0, '0);
                end
                default: begin
                    fn = 3'($urandom_range(7));
                    if (fn == 3'd1 || $urandom_range(2) == 0) fn = CMD_SEARCH;
                    run_command_seq(rand_cmd(fn), $urandom_range(1) ? 0 : 15);
                end
            endcase
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
sv/btc_pkg.sv
sv/btc_front.sv
sv/btc_back.sv
sv/block_tape_controller.sv
sim/tb_top.sv
